/* src/rsps_pkg.sv */
// Package for the radar sweep pixel shader: item types, color constants and shading helpers.
`default_nettype none

package rsps_pkg;

    localparam int          TARGET_SLOTS_DFLT = 3;
    localparam logic [10:0] SCREEN_WIDTH      = 11'd240;
    localparam logic [10:0] CENTER            = 11'd120;
    localparam logic [7:0]  TAIL_LEN          = 8'd24;

    localparam logic [15:0] COL_BLACK  = 16'h0000;
    localparam logic [15:0] COL_BRIGHT = 16'hE007;
    localparam logic [15:0] COL_DIM    = 16'h2003;
    localparam logic [15:0] COL_FAINT  = 16'h6001;

    // distance thresholds on k = radius_code - 1 (dist = k*110/254)
    localparam logic [7:0] K_FAR3 = 8'd7;     // dist > 3
    localparam logic [7:0] K_FAR5 = 8'd12;    // dist > 5
    // |dist - ring| < 1.2 for rings at 1/3, 2/3 and 3/3 of the radius
    localparam logic [7:0] RING1_LO = 8'd82;
    localparam logic [7:0] RING1_HI = 8'd87;
    localparam logic [7:0] RING2_LO = 8'd167;
    localparam logic [7:0] RING2_HI = 8'd172;
    localparam logic [7:0] RING3_LO = 8'd252;

    typedef enum logic [1:0] {
        OP_SHADE  = 2'd0,
        OP_TARGET = 2'd1,
        OP_SWEEP  = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        SIGN_ZERO = 2'b00,
        SIGN_POS  = 2'b01,
        SIGN_NEG  = 2'b10
    } t_sign;

    typedef struct packed {
        t_op        op;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] rc;
        logic [7:0] ang;
        logic [7:0] sweep;
        logic [1:0] slot;
        logic       active;
        logic [7:0] dot_x;
        logic [7:0] dot_y;
        logic [7:0] level;
    } t_item;

    typedef struct packed {
        logic       active;
        logic [7:0] x;
        logic [7:0] y;
        logic [5:0] green;
    } t_target;

    // byte-swapped RGB565 word with only the green field set
    function automatic logic [15:0] green_word(input logic [5:0] g);
        logic [15:0] w;
        w = {5'b0, g, 5'b0};
        return {w[7:0], w[15:8]};
    endfunction

    // floor(level*63/255), divide by 255 via (v + (v>>8) + 1) >> 8
    function automatic logic [5:0] level_to_green(input logic [7:0] level);
        logic [14:0] v;
        logic [14:0] s;
        v = 15'(level) * 15'd63;
        s = v + (v >> 8) + 15'd1;
        return s[13:8];
    endfunction

    // green field of the tail, indexed by steps behind the sweep
    function automatic logic [5:0] tail_green(input logic [4:0] b);
        logic [5:0] g;
        case (b)
            5'd1:    g = 6'd60;
            5'd2:    g = 6'd57;
            5'd3:    g = 6'd55;
            5'd4:    g = 6'd52;
            5'd5:    g = 6'd50;
            5'd6:    g = 6'd47;
            5'd7:    g = 6'd45;
            5'd8:    g = 6'd42;
            5'd9:    g = 6'd40;
            5'd10:   g = 6'd37;
            5'd11:   g = 6'd35;
            5'd12:   g = 6'd32;
            5'd13:   g = 6'd30;
            5'd14:   g = 6'd27;
            5'd15:   g = 6'd25;
            5'd16:   g = 6'd22;
            5'd17:   g = 6'd20;
            5'd18:   g = 6'd17;
            5'd19:   g = 6'd15;
            5'd20:   g = 6'd12;
            5'd21:   g = 6'd9;
            5'd22:   g = 6'd7;
            5'd23:   g = 6'd4;
            5'd24:   g = 6'd2;
            default: g = 6'd0;
        endcase
        return g;
    endfunction

    // exact sign of (u - b*sqrt(3)) by comparing squares
    function automatic t_sign r3_sign(input logic signed [10:0] u,
                                      input logic signed [10:0] b);
        logic [9:0]  ua;
        logic [9:0]  ba;
        logic [21:0] uu;
        logic [19:0] bsq;
        logic [21:0] bb;
        t_sign       r;
        ua  = u[10] ? 10'(-u) : 10'(u);
        ba  = b[10] ? 10'(-b) : 10'(b);
        uu  = 22'(20'(ua) * 20'(ua));
        bsq = 20'(ba) * 20'(ba);
        bb  = 22'(bsq) + {1'b0, bsq, 1'b0};
        if (!u[10] && (b[10] || b == 11'sd0)) begin
            r = (u == 11'sd0 && b == 11'sd0) ? SIGN_ZERO : SIGN_POS;
        end else if ((u[10] || u == 11'sd0) && !b[10]) begin
            r = SIGN_NEG;
        end else if (!u[10]) begin
            r = (uu > bb) ? SIGN_POS : ((uu < bb) ? SIGN_NEG : SIGN_ZERO);
        end else begin
            r = (uu > bb) ? SIGN_NEG : ((uu < bb) ? SIGN_POS : SIGN_ZERO);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* src/radar_sweep_pixel_shader_unit.sv */
// Radar sweep pixel shader: input register, one-pass shading logic, result register.
//
// Input channel (i_in_valid / o_in_stall) carries one request per transfer:
//   shade a pixel, write a target dot entry, or set the sweep position.
// Output channel (o_out_valid / i_out_stall) carries one pixel color per
//   shade request; the other requests give no output transfer.
// A request is held in the input register, where it is shaded or
//   written to the target table / sweep register; a shade result is then
//   registered in the result register, which drives o_pixel_color.
// Throughput is one request per cycle unless a stalled result holds the input,
//   set by the single shading pass between the input and result registers.
// A table or sweep write takes effect for the very next request.
// When the receiver stalls, the result register holds; a shade request waiting
//   behind it stalls the input, while table and sweep writes keep flowing.
// Reset (synchronous, active low) empties both registers, clears the sweep
//   position and marks every target entry inactive.
`default_nettype none

module radar_sweep_pixel_shader_unit #(
    parameter int TARGET_SLOTS = rsps_pkg::TARGET_SLOTS_DFLT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_operation,
    input  wire logic [7:0]  i_pixel_x,
    input  wire logic [7:0]  i_pixel_y,
    input  wire logic [7:0]  i_radius_code,
    input  wire logic [7:0]  i_angle_code,
    input  wire logic [7:0]  i_sweep_code,
    input  wire logic [1:0]  i_slot,
    input  wire logic        i_dot_active,
    input  wire logic [7:0]  i_dot_x,
    input  wire logic [7:0]  i_dot_y,
    input  wire logic [7:0]  i_dot_level,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [15:0]      o_pixel_color
);

    rsps_pkg::t_item   r_s1;
    logic              r_s1_vld;
    logic              n_s1_vld;
    logic [7:0]        r_sweep;
    rsps_pkg::t_target r_tgt [TARGET_SLOTS];
    logic              r_out_vld;
    logic              n_out_vld;
    logic [15:0]       r_color;
    logic [15:0]       n_color;

    logic in_xfer;
    logic out_free;
    logic s1_adv;
    logic s1_shade;

    assign s1_shade   = (r_s1.op == rsps_pkg::OP_SHADE);
    assign out_free   = !r_out_vld || !i_out_stall;
    assign s1_adv     = r_s1_vld && (!s1_shade || out_free);
    assign o_in_stall = r_s1_vld && !s1_adv;
    assign in_xfer    = i_in_valid && !o_in_stall;

    assign n_s1_vld  = in_xfer || (r_s1_vld && !s1_adv);
    assign n_out_vld = (s1_adv && s1_shade) || (r_out_vld && i_out_stall);

    // shading pass
    logic               [7:0]  k;
    logic               [7:0]  ahead;
    logic               [7:0]  behind;
    logic                      far3;
    logic                      far5;
    logic signed        [10:0] px;
    logic signed        [10:0] py;
    logic                      ray_a;
    logic                      ray_b;
    logic                      ring;
    logic               [15:0] base;

    always_comb begin
        k      = r_s1.rc - 8'd1;
        ahead  = r_s1.ang - r_sweep;
        behind = r_sweep - r_s1.ang;
        far3   = (k >= rsps_pkg::K_FAR3);
        far5   = (k >= rsps_pkg::K_FAR5);
        px     = $signed(11'(r_s1.x)) - $signed(rsps_pkg::CENTER);
        py     = $signed(11'(r_s1.y)) - $signed(rsps_pkg::CENTER);
        ray_a  = (rsps_pkg::r3_sign(px - 11'sd3, py) == rsps_pkg::SIGN_NEG)
              && (rsps_pkg::r3_sign(px + 11'sd3, py) == rsps_pkg::SIGN_POS)
              && (rsps_pkg::r3_sign(-py, px) == rsps_pkg::SIGN_NEG);
        ray_b  = (rsps_pkg::r3_sign(-11'sd3 - px, py) == rsps_pkg::SIGN_NEG)
              && (rsps_pkg::r3_sign(11'sd3 - px, py) == rsps_pkg::SIGN_POS)
              && (rsps_pkg::r3_sign(py, px) == rsps_pkg::SIGN_POS);
        ring   = (k >= rsps_pkg::RING1_LO && k <= rsps_pkg::RING1_HI)
              || (k >= rsps_pkg::RING2_LO && k <= rsps_pkg::RING2_HI)
              || (k >= rsps_pkg::RING3_LO);

        if (r_s1.rc == 8'd0) begin
            base = rsps_pkg::COL_BLACK;
        end else if ((ahead <= 8'd1 || ahead >= 8'd254) && far3) begin
            base = rsps_pkg::COL_BRIGHT;
        end else if (behind != 8'd0 && behind <= rsps_pkg::TAIL_LEN && far3) begin
            base = rsps_pkg::green_word(rsps_pkg::tail_green(behind[4:0]));
        end else if (far5 && (ray_a || ray_b)) begin
            base = rsps_pkg::COL_DIM;
        end else if (ring) begin
            base = rsps_pkg::COL_FAINT;
        end else begin
            base = rsps_pkg::COL_BLACK;
        end
    end

    // target dots, max-merged over the slots
    logic signed [8:0]  dx;
    logic signed [8:0]  dy;
    logic signed [3:0]  dxn;
    logic signed [3:0]  dyn;
    logic        [5:0]  d2;
    logic        [15:0] dot_c;

    always_comb begin
        n_color = base;
        dx      = '0;
        dy      = '0;
        dxn     = '0;
        dyn     = '0;
        d2      = '0;
        dot_c   = '0;
        for (int s = 0; s < TARGET_SLOTS; s++) begin
            dx    = $signed({1'b0, r_s1.x}) - $signed({1'b0, r_tgt[s].x});
            dy    = $signed({1'b0, r_s1.y}) - $signed({1'b0, r_tgt[s].y});
            dxn   = dx[3:0];
            dyn   = dy[3:0];
            d2    = 6'(dxn * dxn) + 6'(dyn * dyn);
            dot_c = rsps_pkg::green_word(r_tgt[s].green);
            if (r_tgt[s].active && 11'(r_s1.x) < rsps_pkg::SCREEN_WIDTH
                && dx >= -9'sd4 && dx <= 9'sd4 && dy >= -9'sd4 && dy <= 9'sd4
                && d2 <= 6'd16 && dot_c > n_color) begin
                n_color = dot_c;
            end
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_sweep   <= 8'd0;
            for (int s = 0; s < TARGET_SLOTS; s++) begin
                r_tgt[s].active <= 1'b0;
            end
        end else begin
            r_s1_vld  <= n_s1_vld;
            r_out_vld <= n_out_vld;
            if (s1_adv && r_s1.op == rsps_pkg::OP_SWEEP) begin
                r_sweep <= r_s1.sweep;
            end
            for (int s = 0; s < TARGET_SLOTS; s++) begin
                if (s1_adv && r_s1.op == rsps_pkg::OP_TARGET && 32'(r_s1.slot) == s) begin
                    r_tgt[s].active <= r_s1.active;
                    r_tgt[s].x      <= r_s1.dot_x;
                    r_tgt[s].y      <= r_s1.dot_y;
                    r_tgt[s].green  <= rsps_pkg::level_to_green(r_s1.level);
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1 <= '{op:     rsps_pkg::t_op'(i_operation),
                      x:      i_pixel_x,
                      y:      i_pixel_y,
                      rc:     i_radius_code,
                      ang:    i_angle_code,
                      sweep:  i_sweep_code,
                      slot:   i_slot,
                      active: i_dot_active,
                      dot_x:  i_dot_x,
                      dot_y:  i_dot_y,
                      level:  i_dot_level};
        end
        if (s1_adv && s1_shade) begin
            r_color <= n_color;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_pixel_color = r_color;

    // writes and no-ops never wait on the output side
    a_nonshade_flows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_vld && !s1_shade |-> !o_in_stall)
        else $error("non-shade request blocked the input");

    // input stalls only behind a shade waiting on a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_s1_vld && s1_shade && r_out_vld && i_out_stall)
        else $error("input stalled without cause");

    // a new result only comes from a shade request
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && r_out_vld && !$past(r_out_vld && i_out_stall)
        |-> $past(r_s1_vld && s1_shade))
        else $error("result without shade request");

    // the sweep position moves only on a sweep transfer
    a_sweep_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && r_sweep != $past(r_sweep)
        |-> $past(s1_adv && r_s1.op == rsps_pkg::OP_SWEEP))
        else $error("sweep position changed without a sweep transfer");

endmodule

`default_nettype wire

/* bench/tb.sv */
// Self-checking testbench for the radar sweep pixel shader unit.
`timescale 1ns / 100ps

module tb;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_ITEMS  = 505;
    localparam int HOLD_CYCLES   = 80;
    localparam int SLOTS         = 3;
    localparam int SCREEN_W      = 240;
    localparam int MID           = 120;
    localparam int TAIL_STEPS    = 24;
    localparam int DIRECTED_ROWS = 25;

    localparam logic [15:0] BLACK_RGB = 16'h0000;
    localparam logic [15:0] SWEEP_RGB = 16'hE007;
    localparam logic [15:0] RAY_RGB   = 16'h2003;
    localparam logic [15:0] RING_RGB  = 16'h6001;

    typedef struct packed {
        rsps_pkg::t_op op;
        logic [7:0]    px;
        logic [7:0]    py;
        logic [7:0]    rc;
        logic [7:0]    ang;
        logic [7:0]    sweep;
        logic [1:0]    slot;
        logic          act;
        logic [7:0]    tx;
        logic [7:0]    ty;
        logic [7:0]    lvl;
        logic          typed;
        logic [15:0]   color;
    } shader_req_t;

    typedef struct packed {
        logic       act;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] lvl;
    } dot_t;

    typedef enum logic [2:0] {AIM_ANY, AIM_SWEEP, AIM_RING, AIM_DOT, AIM_RAY} aim_t;
    typedef enum logic [1:0] {FLOW, LIGHT, HEAVY, TOGGLE} stall_mode_t;

    // typed colors only where obvious; the rest go through the predictor
    localparam shader_req_t DIRECTED [DIRECTED_ROWS] = '{
        '{op: rsps_pkg::OP_SHADE, px: 0, py: 0, rc: 0, ang: 0, typed: 1,
          color: BLACK_RGB, default: '0},
        '{op: rsps_pkg::OP_SHADE, px: 239, py: 239, rc: 255, ang: 0, typed: 1,
          color: SWEEP_RGB, default: '0},
        '{op: rsps_pkg::OP_SHADE, px: 255, py: 255, rc: 255, ang: 255, typed: 1,
          color: SWEEP_RGB, default: '0},
        '{op: rsps_pkg::OP_SHADE, px: 120, py: 120, rc: 8, ang: 1, typed: 1,
          color: SWEEP_RGB, default: '0},
        '{op: rsps_pkg::OP_SHADE, px: 120, py: 120, rc: 7, ang: 0, typed: 1,
          color: BLACK_RGB, default: '0},
        '{op: rsps_pkg::OP_SWEEP, sweep: 100, default: '0},
        '{op: rsps_pkg::OP_SHADE, px: 10, py: 10, rc: 200, ang: 97, default: '0},
        '{op: rsps_pkg::OP_SHADE, px: 10, py: 10, rc: 200, ang: 76, default: '0},
        '{op: rsps_pkg::OP_SHADE, px: 172, py: 150, rc: 150, ang: 200, default: '0},
        '{op: rsps_pkg::OP_SHADE, px: 68, py: 150, rc: 150, ang: 200, default: '0},
        '{op: rsps_pkg::OP_SHADE, px: 120, py: 0, rc: 86, ang: 200, default: '0},
        '{op: rsps_pkg::OP_SHADE, px: 120, py: 0, rc: 255, ang: 200, default: '0},
        '{op: rsps_pkg::OP_TARGET, slot: 0, act: 1, tx: 60, ty: 60, lvl: 255,
          default: '0},
        '{op: rsps_pkg::OP_SHADE, px: 60, py: 60, rc: 0, default: '0},
        '{op: rsps_pkg::OP_SHADE, px: 64, py: 60, rc: 0, default: '0},
        '{op: rsps_pkg::OP_SHADE, px: 63, py: 63, rc: 0, default: '0},
        '{op: rsps_pkg::OP_TARGET, slot: 3, act: 1, tx: 100, ty: 100, lvl: 255,
          default: '0},
        '{op: rsps_pkg::OP_SHADE, px: 100, py: 100, rc: 0, default: '0},
        '{op: rsps_pkg::OP_NOP, px: 255, py: 255, rc: 255, ang: 255, sweep: 255, slot: 3,
          act: 1, tx: 255, ty: 255, lvl: 255, default: '0},
        '{op: rsps_pkg::OP_TARGET, slot: 2, act: 1, tx: 250, ty: 10, lvl: 200,
          default: '0},
        '{op: rsps_pkg::OP_SHADE, px: 250, py: 10, rc: 0, default: '0},
        '{op: rsps_pkg::OP_TARGET, slot: 1, act: 1, tx: 120, ty: 0, lvl: 100,
          default: '0},
        '{op: rsps_pkg::OP_SHADE, px: 120, py: 2, rc: 86, ang: 200, default: '0},
        '{op: rsps_pkg::OP_SWEEP, sweep: 255, default: '0},
        '{op: rsps_pkg::OP_TARGET, slot: 0, act: 0, tx: 60, ty: 60, lvl: 255,
          default: '0}
    };

    logic          i_clk     = 1'b0;
    logic          rst_n     = 1'b0;
    logic          in_valid  = 1'b0;
    rsps_pkg::t_op in_op     = rsps_pkg::OP_SHADE;
    logic [7:0]    in_px     = '0;
    logic [7:0]    in_py     = '0;
    logic [7:0]    in_rc     = '0;
    logic [7:0]    in_ang    = '0;
    logic [7:0]    in_sweep  = '0;
    logic [1:0]    in_slot   = '0;
    logic          in_act    = 1'b0;
    logic [7:0]    in_tx     = '0;
    logic [7:0]    in_ty     = '0;
    logic [7:0]    in_lvl    = '0;
    logic          in_typed  = 1'b0;
    logic [15:0]   in_color  = '0;
    logic          out_stall = 1'b0;

    logic        o_in_stall;
    logic        o_out_valid;
    logic [15:0] o_pixel_color;

    // predictor state
    logic [7:0]  sweep_pos = '0;
    dot_t        dots [SLOTS];
    logic [15:0] color_queue [$];

    int errors      = 0;
    int shades      = 0;
    int dot_writes  = 0;
    int sweep_sets  = 0;
    int ignored     = 0;
    int holds_asked = 0;
    int holds_done  = 0;
    int burst_left  = 0;
    int cycle_count = 0;

    radar_sweep_pixel_shader_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (o_in_stall),
        .i_operation   (in_op),
        .i_pixel_x     (in_px),
        .i_pixel_y     (in_py),
        .i_radius_code (in_rc),
        .i_angle_code  (in_ang),
        .i_sweep_code  (in_sweep),
        .i_slot        (in_slot),
        .i_dot_active  (in_act),
        .i_dot_x       (in_tx),
        .i_dot_y       (in_ty),
        .i_dot_level   (in_lvl),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (out_stall),
        .o_pixel_color (o_pixel_color)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [15:0] green_swapped(input logic [7:0] lvl);
        logic [15:0] w;
        w = 16'((int'(lvl) * 63 / 255) << 5);
        return {w[7:0], w[15:8]};
    endfunction

    // sign of u - b*sqrt(3), exact via squares
    function automatic int root3_side(input int u, input int b);
        if (u >= 0 && b <= 0) return (u == 0 && b == 0) ? 0 : 1;
        if (u <= 0 && b >= 0) return -1;
        if (u > 0) return (u * u > 3 * b * b) ? 1 : ((u * u < 3 * b * b) ? -1 : 0);
        return (u * u > 3 * b * b) ? -1 : ((u * u < 3 * b * b) ? 1 : 0);
    endfunction

    function automatic logic [15:0] shade_color(input logic [7:0] xc, input logic [7:0] yc,
                                                input logic [7:0] rc, input logic [7:0] ang);
        logic [15:0] pix;
        logic [15:0] c;
        int          px, py, k, ahead, behind, e, d, ddx, ddy;
        bit          far3;
        bit          ring;
        pix = BLACK_RGB;
        px  = int'(xc) - MID;
        py  = int'(yc) - MID;
        if (rc != 8'd0) begin
            k      = int'(rc) - 1;
            ahead  = (int'(ang) - int'(sweep_pos)) & 255;
            behind = (int'(sweep_pos) - int'(ang)) & 255;
            far3   = 110 * k > 762;
            if ((ahead <= 1 || ahead >= 254) && far3) begin
                pix = SWEEP_RGB;
            end else if (behind >= 1 && behind <= TAIL_STEPS && far3) begin
                pix = green_swapped(8'(255 * (TAIL_STEPS + 1 - behind) / (TAIL_STEPS + 1)));
            end else begin
                e = 330 * k;
                if (110 * k > 1270) begin
                    if (root3_side(px - 3, py) < 0 && root3_side(px + 3, py) > 0 &&
                        root3_side(-py, px) < 0)
                        pix = RAY_RGB;
                    if (root3_side(-3 - px, py) < 0 && root3_side(3 - px, py) > 0 &&
                        root3_side(py, px) > 0)
                        pix = RAY_RGB;
                end
                ring = 1'b0;
                for (int i = 1; i <= 3; i++) begin
                    d = e - 27940 * i;
                    if (d < 0) d = -d;
                    if (5 * d < 4572) ring = 1'b1;
                end
                if (pix == BLACK_RGB && ring) pix = RING_RGB;
            end
        end
        if (int'(xc) < SCREEN_W) begin
            for (int t = 0; t < SLOTS; t++) begin
                if (dots[t].act) begin
                    ddx = int'(xc) - int'(dots[t].x);
                    ddy = int'(yc) - int'(dots[t].y);
                    if (ddx >= -4 && ddx <= 4 && ddy >= -4 && ddy <= 4 &&
                        ddx * ddx + ddy * ddy <= 16) begin
                        c = green_swapped(dots[t].lvl);
                        if (c > pix) pix = c;
                    end
                end
            end
        end
        return pix;
    endfunction

    // mostly aimed shades, some table/sweep writes, a little noise
    function automatic shader_req_t draw_request();
        shader_req_t r;
        int          pick, s, dy, off;
        r.op    = rsps_pkg::OP_SHADE;
        r.px    = 8'($urandom);
        r.py    = 8'($urandom);
        r.rc    = 8'($urandom);
        r.ang   = 8'($urandom);
        r.sweep = 8'($urandom);
        r.slot  = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
        r.act   = ($urandom_range(0, 4) != 0);
        r.tx    = 8'($urandom);
        r.ty    = 8'($urandom);
        r.lvl   = 8'($urandom);
        r.typed = 1'b0;
        r.color = '0;
        pick    = $urandom_range(0, 99);
        if (pick < 10) begin
            r.op = rsps_pkg::OP_TARGET;
        end else if (pick < 15) begin
            r.op = rsps_pkg::OP_SWEEP;
        end else if (pick < 18) begin
            r.op = rsps_pkg::OP_NOP;
        end else begin
            case (aim_t'($urandom_range(0, 4)))
                AIM_SWEEP: begin
                    r.ang = sweep_pos + 8'($urandom_range(0, 32)) - 8'd28;
                end
                AIM_RING: begin
                    s    = 85 * $urandom_range(1, 3) + $urandom_range(0, 12) - 6;
                    r.rc = 8'((s > 255) ? 255 : s);
                end
                AIM_DOT: begin
                    s    = $urandom_range(0, SLOTS - 1);
                    r.px = dots[s].x + 8'($urandom_range(0, 10)) - 8'd5;
                    r.py = dots[s].y + 8'($urandom_range(0, 10)) - 8'd5;
                end
                AIM_RAY: begin
                    dy   = $urandom_range(1, 68);
                    off  = dy * 1732 / 1000 + $urandom_range(0, 6) - 3;
                    r.py = 8'(MID + dy);
                    r.px = 8'($urandom_range(0, 1) ? MID + off : MID - off);
                end
                default: ;
            endcase
        end
        return r;
    endfunction

    task automatic push_req(input shader_req_t r);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 100)
                                                     : $urandom_range(1, 20);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_op    <= r.op;
        in_px    <= r.px;
        in_py    <= r.py;
        in_rc    <= r.rc;
        in_ang   <= r.ang;
        in_sweep <= r.sweep;
        in_slot  <= r.slot;
        in_act   <= r.act;
        in_tx    <= r.tx;
        in_ty    <= r.ty;
        in_lvl   <= r.lvl;
        in_typed <= r.typed;
        in_color <= r.color;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // predictor update on input transfers, compare on output transfers
    always @(posedge i_clk) begin : scoreboard
        logic [15:0] want;
        if (rst_n) begin
            if (o_out_valid && !out_stall) begin
                if (color_queue.size() == 0) begin
                    $error("pixel_color: expected none, got %h", o_pixel_color);
                    errors++;
                end else begin
                    want = color_queue.pop_front();
                    if (o_pixel_color !== want) begin
                        $error("pixel_color: expected %h, got %h", want, o_pixel_color);
                        errors++;
                    end
                end
            end
            if (in_valid && !o_in_stall) begin
                case (in_op)
                    rsps_pkg::OP_SHADE: begin
                        color_queue.push_back(in_typed ? in_color
                                              : shade_color(in_px, in_py, in_rc, in_ang));
                        shades++;
                    end
                    rsps_pkg::OP_TARGET: begin
                        if (int'(in_slot) < SLOTS) begin
                            dots[in_slot] = '{act: in_act, x: in_tx, y: in_ty, lvl: in_lvl};
                            dot_writes++;
                        end else begin
                            ignored++;
                        end
                    end
                    rsps_pkg::OP_SWEEP: begin
                        sweep_pos = in_sweep;
                        sweep_sets++;
                    end
                    default: ignored++;
                endcase
            end
        end
    end

    initial begin : receiver
        stall_mode_t mode;
        int          left;
        mode = FLOW;
        left = 0;
        forever begin
            @(posedge i_clk);
            if (holds_done < holds_asked) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
                holds_done++;
            end else begin
                if (left == 0) begin
                    mode = stall_mode_t'($urandom_range(0, 3));
                    left = $urandom_range(8, 60);
                end
                left--;
                case (mode)
                    FLOW:    out_stall <= 1'b0;
                    LIGHT:   out_stall <= ($urandom_range(0, 4) == 0);
                    HEAVY:   out_stall <= ($urandom_range(0, 3) != 0);
                    default: out_stall <= ~out_stall;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[radar_sweep_pixel_shader_unit] ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        shader_req_t r;
        int          applied;
        int          sent;
        foreach (dots[i]) dots[i] = '0;
        repeat (7) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (DIRECTED[i]) push_req(DIRECTED[i]);
        applied = 0;
        sent    = 0;
        while (applied < RANDOM_ITEMS) begin
            r = draw_request();
            if (r.op == rsps_pkg::OP_SHADE || r.op == rsps_pkg::OP_SWEEP ||
                (r.op == rsps_pkg::OP_TARGET && int'(r.slot) < SLOTS))
                applied++;
            if (sent == 30 || sent == 300) holds_asked <= holds_asked + 1;
            sent++;
            push_req(r);
        end
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (color_queue.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        $display("Covered %0d shaded pixels, %0d dot writes, %0d sweep updates, %0d ignored",
                 shades, dot_writes, sweep_sets, ignored);
        $display("Receiver held off %0d times for %0d cycles", holds_done, HOLD_CYCLES);
        if (errors == 0) begin
            $display("[radar_sweep_pixel_shader_unit] OK");
        end else begin
            $display("[radar_sweep_pixel_shader_unit] ERROR");
        end
        $finish;
    end

endmodule
